[rtl/ald_pkg.sv]
package ald_pkg;

    localparam int DEF_FRAME_WIDTH  = 128;
    localparam int DEF_FRAME_HEIGHT = 128;

    localparam int COORD_W = 7;
    localparam int CHAN_W  = 8;
    localparam int PIXEL_W = 3 * CHAN_W;
    localparam int LUMA_W  = 18;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 24;
    localparam int DIV_NUM_W = COORD_W + 16;
    localparam int DIV_CNT_W = 5;

    typedef enum logic [1:0] {
        OP_LINE  = 2'd0,
        OP_WRITE = 2'd1,
        OP_READ  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        CFG_CLIP_LEFT   = 2'd0,
        CFG_CLIP_TOP    = 2'd1,
        CFG_CLIP_RIGHT  = 2'd2,
        CFG_CLIP_BOTTOM = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD_WAIT,
        ST_L_FIRST,
        ST_L_SOLID,
        ST_L_DIV,
        ST_L_STEP,
        ST_B_RD,
        ST_B_LUM,
        ST_B_MUL,
        ST_B_WR,
        ST_L_LAST
    } state_t;

    function automatic logic [LUMA_W-1:0] luma(input logic [PIXEL_W-1:0] rgb);
        logic [LUMA_W-1:0] r, g, b;
        r = LUMA_W'(rgb[23:16]);
        g = LUMA_W'(rgb[15:8]);
        b = LUMA_W'(rgb[7:0]);
        return LUMA_W'(r * 18'd299 + g * 18'd587 + b * 18'd114);
    endfunction

    // floor(p / 255) for p below 65280
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] p);
        logic [16:0] s;
        s = 17'(p) + 17'(p[15:8]) + 17'd1;
        return s[15:8];
    endfunction

endpackage

[rtl/ald_ram.sv]
module ald_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/antialiased_line_drawer_core.sv]
// Antialiased line drawer with a 24-bit RGB frame store.
// Input channel s_*: one command per transfer; s_tuser holds the operation
// (line, pixel write, pixel read), s_tdata the coordinates and colour.
// Result channel m_*: one transfer per pixel read, carrying the stored colour.
// Configuration: cfg_we/cfg_addr/cfg_wdata write the clip rectangle.
// After reset the store is cleared one pixel per cycle, all FRAME_WIDTH *
// FRAME_HEIGHT pixels (16384 by default); s_tready stays low during that pass.
// A pixel write is stored when accepted; a pixel read goes through a wait state to the output register.
// Line: the first pixel is written, then solid lines take 1 cycle per pixel
// and return to idle; other lines run a serial division, load the step, make
// two read-modify-write passes per major-axis step (read, luma, multiply and
// write states, through the single store port pair) and finish with the
// last pixel.
// One command is processed at a time. A read result waits in the output
// register while m_tready is low; the next command is taken meanwhile, and a
// further read holds in its wait state until the register is free.
module antialiased_line_drawer_core #(
    parameter int FRAME_WIDTH  = ald_pkg::DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = ald_pkg::DEF_FRAME_HEIGHT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ald_pkg::S_DATA_W-1:0]    s_tdata,  // start_x, start_y, end_x, end_y, red, green, blue
    input  logic [1:0]                      s_tuser,  // operation
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ald_pkg::M_DATA_W-1:0]    m_tdata,  // read_red, read_green, read_blue
    input  logic                            cfg_we,
    input  logic [ald_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [ald_pkg::COORD_W-1:0]     cfg_wdata
);
    import ald_pkg::*;

    localparam int DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [PIXEL_W-1:0] pixel_t;

    function automatic logic [ADDR_W-1:0] px_addr(input coord_t x, input coord_t y);
        return ADDR_W'(32'(y) * FRAME_WIDTH + 32'(x));
    endfunction

    function automatic logic in_frame(input coord_t x, input coord_t y);
        return (32'(x) < FRAME_WIDTH) && (32'(y) < FRAME_HEIGHT);
    endfunction

    state_t state_reg, state_next;
    coord_t clip_l_reg, clip_t_reg, clip_r_reg, clip_b_reg;
    coord_t x0_reg, x0_next, y0_reg, y0_next, x1_reg, x1_next, y1_reg, y1_next;
    pixel_t color_reg, color_next;
    logic [LUMA_W-1:0] lline_reg, lline_next;
    coord_t col_reg, col_next, row_reg, row_next;
    coord_t px_reg, px_next, py_reg, py_next;
    logic [15:0] acc_reg, acc_next, adj_reg, adj_next;
    logic [7:0] steps_reg, steps_next;
    logic neg_reg, neg_next, ymaj_reg, ymaj_next;
    logic paired_reg, paired_next, inf_reg, inf_next;
    logic [DIV_NUM_W-1:0] num_reg, num_next;
    logic [COORD_W:0] rem_reg, rem_next;
    coord_t den_reg, den_next;
    logic [DIV_CNT_W-1:0] dcnt_reg, dcnt_next;
    logic [CHAN_W-1:0] wt_reg, wt_next;
    pixel_t bg_reg, bg_next;
    logic [CHAN_W-1:0] lo_reg [3];
    logic [CHAN_W-1:0] lo_next [3];
    logic [15:0] prod_reg [3];
    logic [15:0] prod_next [3];
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic m_valid_reg, m_valid_next;
    pixel_t m_data_reg, m_data_next;

    logic ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    pixel_t ram_wdata, ram_rdata;

    coord_t s_sx, s_sy, s_ex, s_ey;
    pixel_t s_color;
    logic accept;

    assign s_sx    = s_tdata[6:0];
    assign s_sy    = s_tdata[13:7];
    assign s_ex    = s_tdata[20:14];
    assign s_ey    = s_tdata[27:21];
    assign s_color = {s_tdata[35:28], s_tdata[43:36], s_tdata[51:44]};
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_data_reg[7:0], m_data_reg[15:8], m_data_reg[23:16]};

    ald_ram #(.WIDTH(PIXEL_W), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clip_l_reg <= '0;
            clip_t_reg <= '0;
            clip_r_reg <= '1;
            clip_b_reg <= '1;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_CLIP_LEFT:   clip_l_reg <= cfg_wdata;
                CFG_CLIP_TOP:    clip_t_reg <= cfg_wdata;
                CFG_CLIP_RIGHT:  clip_r_reg <= cfg_wdata;
                CFG_CLIP_BOTTOM: clip_b_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            acc_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            steps_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            m_valid_reg <= m_valid_next;
            acc_reg     <= acc_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            steps_reg   <= steps_next;
        end
    end

    always_ff @(posedge aclk) begin
        x0_reg     <= x0_next;
        y0_reg     <= y0_next;
        x1_reg     <= x1_next;
        y1_reg     <= y1_next;
        color_reg  <= color_next;
        lline_reg  <= lline_next;
        px_reg     <= px_next;
        py_reg     <= py_next;
        adj_reg    <= adj_next;
        neg_reg    <= neg_next;
        ymaj_reg   <= ymaj_next;
        paired_reg <= paired_next;
        inf_reg    <= inf_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        dcnt_reg   <= dcnt_next;
        wt_reg     <= wt_next;
        bg_reg     <= bg_next;
        lo_reg     <= lo_next;
        prod_reg   <= prod_next;
        m_data_reg <= m_data_next;
    end

    coord_t dx, dy, step_c, pcol, prow, ncol, nrow;
    logic [15:0] acc_sum;
    logic [COORD_W:0] dtry;
    pixel_t bg_eff;
    logic darker, clip_ok;
    logic [CHAN_W-1:0] ch_a, ch_b;

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        acc_next     = acc_reg;
        col_next     = col_reg;
        row_next     = row_reg;
        steps_next   = steps_reg;
        x0_next = x0_reg; y0_next = y0_reg; x1_next = x1_reg; y1_next = y1_reg;
        color_next  = color_reg;
        lline_next  = lline_reg;
        px_next     = px_reg;
        py_next     = py_reg;
        adj_next    = adj_reg;
        neg_next    = neg_reg;
        ymaj_next   = ymaj_reg;
        paired_next = paired_reg;
        inf_next    = inf_reg;
        num_next    = num_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        dcnt_next   = dcnt_reg;
        wt_next     = wt_reg;
        bg_next     = bg_reg;
        lo_next     = lo_reg;
        prod_next   = prod_reg;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;

        dx     = (x1_reg >= x0_reg) ? x1_reg - x0_reg : x0_reg - x1_reg;
        dy     = y1_reg - y0_reg;
        step_c = neg_reg ? '1 : COORD_W'(1);
        acc_sum = acc_reg + adj_reg;
        dtry   = {rem_reg[COORD_W-1:0], num_reg[DIV_NUM_W-1]} - {1'b0, den_reg};
        ncol   = col_reg + step_c;
        nrow   = row_reg + COORD_W'(1);
        pcol   = ymaj_reg ? col_reg + step_c : col_reg;
        prow   = ymaj_reg ? row_reg : row_reg + COORD_W'(1);
        bg_eff = inf_reg ? ram_rdata : '0;
        darker = lline_reg < luma(bg_eff);
        clip_ok = s_sx >= clip_l_reg && s_sx <= clip_r_reg && s_sy >= clip_t_reg
                  && s_sy <= clip_b_reg && s_ex >= clip_l_reg && s_ex <= clip_r_reg
                  && s_ey >= clip_t_reg && s_ey <= clip_b_reg;
        ch_a = '0;
        ch_b = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + ADDR_W'(1);
                if (clr_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    color_next = s_color;
                    lline_next = luma(s_color);
                    inf_next   = in_frame(s_sx, s_sy);
                    unique case (op_t'(s_tuser))
                        OP_WRITE: begin
                            ram_we    = in_frame(s_sx, s_sy);
                            ram_waddr = px_addr(s_sx, s_sy);
                            ram_wdata = s_color;
                        end
                        OP_READ: begin
                            ram_re     = 1'b1;
                            ram_raddr  = px_addr(s_sx, s_sy);
                            state_next = ST_RD_WAIT;
                        end
                        OP_LINE: begin
                            if (clip_ok) begin
                                if (s_sy > s_ey) begin
                                    x0_next = s_ex; y0_next = s_ey;
                                    x1_next = s_sx; y1_next = s_sy;
                                end else begin
                                    x0_next = s_sx; y0_next = s_sy;
                                    x1_next = s_ex; y1_next = s_ey;
                                end
                                state_next = ST_L_FIRST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD_WAIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = bg_eff;
                    state_next   = ST_IDLE;
                end
            end
            ST_L_FIRST: begin
                ram_we    = in_frame(x0_reg, y0_reg);
                ram_waddr = px_addr(x0_reg, y0_reg);
                ram_wdata = color_reg;
                neg_next  = x1_reg < x0_reg;
                ymaj_next = dy > dx;
                col_next  = x0_reg;
                row_next  = y0_reg;
                if (dy == '0 || dx == '0 || dx == dy) begin
                    steps_next = 8'(dy == '0 ? dx : dy);
                    state_next = ST_L_SOLID;
                end else begin
                    acc_next   = '0;
                    num_next   = {(dy > dx) ? dx : dy, 16'd0};
                    den_next   = (dy > dx) ? dy : dx;
                    rem_next   = '0;
                    dcnt_next  = '0;
                    steps_next = 8'((dy > dx) ? dy : dx) - 8'd1;
                    state_next = ST_L_DIV;
                end
            end
            ST_L_SOLID: begin
                if (steps_reg == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    ch_a = (dx != '0) ? 8'(ncol) : 8'(col_reg);
                    ch_b = (dy != '0) ? 8'(nrow) : 8'(row_reg);
                    col_next   = ch_a[COORD_W-1:0];
                    row_next   = ch_b[COORD_W-1:0];
                    ram_we     = in_frame(ch_a[COORD_W-1:0], ch_b[COORD_W-1:0]);
                    ram_waddr  = px_addr(ch_a[COORD_W-1:0], ch_b[COORD_W-1:0]);
                    ram_wdata  = color_reg;
                    steps_next = steps_reg - 8'd1;
                end
            end
            ST_L_DIV: begin
                if (!dtry[COORD_W]) begin
                    rem_next = dtry;
                    num_next = {num_reg[DIV_NUM_W-2:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[COORD_W-1:0], num_reg[DIV_NUM_W-1]};
                    num_next = {num_reg[DIV_NUM_W-2:0], 1'b0};
                end
                dcnt_next = dcnt_reg + DIV_CNT_W'(1);
                if (dcnt_reg == DIV_CNT_W'(DIV_NUM_W - 1)) begin
                    state_next = ST_L_STEP;
                end
            end
            ST_L_STEP: begin
                if (dcnt_reg == DIV_CNT_W'(DIV_NUM_W)) begin
                    adj_next  = num_reg[15:0];
                    dcnt_next = '0;
                end else if (steps_reg == '0) begin
                    state_next = ST_L_LAST;
                end else begin
                    acc_next = acc_sum;
                    if (ymaj_reg) begin
                        row_next = nrow;
                        col_next = (acc_sum <= acc_reg) ? ncol : col_reg;
                    end else begin
                        col_next = ncol;
                        row_next = (acc_sum <= acc_reg) ? nrow : row_reg;
                    end
                    px_next     = col_next;
                    py_next     = row_next;
                    paired_next = 1'b0;
                    state_next  = ST_B_RD;
                end
            end
            ST_B_RD: begin
                ram_re     = 1'b1;
                ram_raddr  = px_addr(px_reg, py_reg);
                inf_next   = in_frame(px_reg, py_reg);
                state_next = ST_B_LUM;
            end
            ST_B_LUM: begin
                bg_next    = bg_eff;
                wt_next    = (darker != paired_reg) ? acc_reg[15:8] : ~acc_reg[15:8];
                state_next = ST_B_MUL;
            end
            ST_B_MUL: begin
                for (int i = 0; i < 3; i++) begin
                    ch_a = bg_reg[8*i +: 8];
                    ch_b = color_reg[8*i +: 8];
                    lo_next[i]   = (ch_a < ch_b) ? ch_a : ch_b;
                    prod_next[i] = 16'(wt_reg) * 16'((ch_a < ch_b) ? ch_b - ch_a : ch_a - ch_b);
                end
                state_next = ST_B_WR;
            end
            ST_B_WR: begin
                ram_we    = inf_reg;
                ram_waddr = px_addr(px_reg, py_reg);
                for (int i = 0; i < 3; i++) begin
                    ram_wdata[8*i +: 8] = lo_reg[i] + div255(prod_reg[i]);
                end
                if (!paired_reg) begin
                    paired_next = 1'b1;
                    px_next     = pcol;
                    py_next     = prow;
                    state_next  = ST_B_RD;
                end else begin
                    steps_next = steps_reg - 8'd1;
                    state_next = ST_L_STEP;
                end
            end
            ST_L_LAST: begin
                ram_we     = in_frame(x1_reg, y1_reg);
                ram_waddr  = px_addr(x1_reg, y1_reg);
                ram_wdata  = color_reg;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("transfer accepted during store clear");

    a_read_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tuser == OP_READ) |=> (state_reg == ST_RD_WAIT))
        else $error("pixel read did not enter wait state");

    a_pair_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_B_WR && paired_reg) |=> (state_reg == ST_L_STEP))
        else $error("paired pixel did not return to walker");

    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(ram_we && ram_re))
        else $error("store read and write in one cycle");

endmodule
